FILE: design/assert_macros.svh
// Assertion helpers; clk and rst_n are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: design/b2da_pkg.sv
package b2da_pkg;

  localparam int BIN_W    = 64;
  localparam int DIGITS   = 20;
  localparam int DIGIT_W  = 4;
  localparam int BCD_W    = DIGITS * DIGIT_W;
  localparam int ITER_W   = $clog2(BIN_W);
  localparam int NDIG_W   = $clog2(DIGITS + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(BIN_W - 1);
  localparam logic [NDIG_W-1:0] NDIG_MAX  = NDIG_W'(DIGITS);
  localparam logic [NDIG_W-1:0] NDIG_ONE  = NDIG_W'(1);

  typedef logic [BCD_W-1:0] bcd_t;
  typedef logic [BIN_W-1:0] bin_t;

endpackage

FILE: design/binary_to_decimal_ascii.sv
// 64-bit binary to decimal ASCII converter. Pulse start while busy is low with
// in_value and in_signed_mode; the text comes out one character per out_valid
// strobe, most significant first, with out_last on the final character. A
// negative signed value is led by '-'. Results cannot be stalled: take each
// character in the cycle it is strobed. busy stays high while an item runs:
// the value passes bit by bit through add-3/shift logic that adjusts every
// digit in parallel, then leading zero digits are skipped one at a time, a
// decision is made, and the characters are emitted. busy drops as the last
// character is strobed, so the next start can be taken in that same cycle.
`include "assert_macros.svh"

module binary_to_decimal_ascii (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [63:0] in_value,
  input  logic       in_signed_mode,
  output logic       out_valid,
  output logic [7:0] out_character,
  output logic       out_last
);
  import b2da_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  state_t              state_r;
  logic [ITER_W-1:0]   iter_r;
  logic [NDIG_W-1:0]   ndig_r;
  logic                neg_r;
  bcd_t                bcd_r;
  bin_t                bin_r;
  logic                out_valid_r;
  logic [7:0]          out_character_r;
  logic                out_last_r;

  bcd_t                bcd_nxt;
  bin_t                bin_nxt;
  logic                in_neg;
  logic [DIGIT_W-1:0]  top_digit;

  b2da_dabble u_dabble (
    .bcd_i (bcd_r),
    .bin_i (bin_r),
    .bcd_o (bcd_nxt),
    .bin_o (bin_nxt)
  );

  assign in_neg    = in_signed_mode & in_value[BIN_W-1];
  assign top_digit = bcd_r[BCD_W-1 -: DIGIT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            bin_r   <= in_neg ? (~in_value + BIN_W'(1)) : in_value;
            neg_r   <= in_neg;
            bcd_r   <= '0;
            iter_r  <= '0;
            ndig_r  <= NDIG_MAX;
            state_r <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd_r  <= bcd_nxt;
          bin_r  <= bin_nxt;
          iter_r <= iter_r + ITER_W'(1);
          if (iter_r == ITER_LAST) begin
            state_r <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // drop leading zeros, always keep at least one digit
          if (top_digit == '0 && ndig_r != NDIG_ONE) begin
            bcd_r  <= {bcd_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            ndig_r <= ndig_r - NDIG_W'(1);
          end else begin
            state_r <= neg_r ? ST_SIGN : ST_DIGIT;
          end
        end
        ST_SIGN: begin
          out_valid_r     <= 1'b1;
          out_character_r <= CHAR_MINUS;
          out_last_r      <= 1'b0;
          state_r         <= ST_DIGIT;
        end
        ST_DIGIT: begin
          out_valid_r     <= 1'b1;
          out_character_r <= CHAR_ZERO | {4'b0000, top_digit};
          out_last_r      <= (ndig_r == NDIG_ONE);
          bcd_r           <= {bcd_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          ndig_r          <= ndig_r - NDIG_W'(1);
          if (ndig_r == NDIG_ONE) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

  `ASSERT_NXT(a_start_busy, start && !busy, busy)
  `ASSERT_IMP(a_beat_while_busy, out_valid, $past(busy))
  `ASSERT_NXT(a_last_ends, out_valid && out_last, !out_valid)
  `ASSERT_IMP(a_char_range, out_valid && out_character != CHAR_MINUS,
              out_character >= CHAR_ZERO && out_character <= CHAR_ZERO + 8'd9)
  `ASSERT_IMP(a_sign_not_last, out_valid && out_character == CHAR_MINUS, !out_last)

endmodule

FILE: design/b2da_dabble.sv
module b2da_dabble (
  input  b2da_pkg::bcd_t bcd_i,
  input  b2da_pkg::bin_t bin_i,
  output b2da_pkg::bcd_t bcd_o,
  output b2da_pkg::bin_t bin_o
);
  import b2da_pkg::*;

  bcd_t adj;

  // add-3 on every digit of 5 or more, then shift the pair left one bit
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_i[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_i[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_i[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign bcd_o = {adj[BCD_W-2:0], bin_i[BIN_W-1]};
  assign bin_o = {bin_i[BIN_W-2:0], 1'b0};

endmodule
